>>> hw/rtl/ovle_pkg.sv
package ovle_pkg;

  // Number of list positions held by the chain.
  localparam int unsigned CAPACITY = 16;

  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned IdxInW   = 4;
  localparam int unsigned CmpW     = (CntW > IdxInW) ? CntW : IdxInW;
  localparam int unsigned ReadSpan = (CAPACITY < (1 << IdxInW)) ? CAPACITY : (1 << IdxInW);
  localparam int unsigned LenW     = 5;

  typedef logic signed [31:0] value_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_DELETE = 2'd3
  } cell_cmd_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    op_e               op;
    value_t            value;
    value_t            match_key;
    logic [IdxInW-1:0] index;
  } in_item_t;

  typedef struct packed {
    status_e         status;
    logic [LenW-1:0] length;
    value_t          read_value;
    logic [LenW-1:0] removed_count;
  } out_item_t;

  // What a cell hands to its right neighbor.
  typedef struct packed {
    logic   occ;
    logic   found;
    value_t entry;
  } cell_link_t;

endpackage

>>> hw/rtl/ovle_cell.sv
module ovle_cell
  import ovle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_cmd_e  cmd_i,
  input  value_t     value_i,
  input  value_t     cmp_i,
  input  cell_link_t left_i,
  input  logic       right_occ_i,
  input  value_t     right_entry_i,
  output cell_link_t link_o
);

  logic   occ_q, occ_d;
  value_t entry_q, entry_d;
  logic   hit;

  assign hit = occ_q && (entry_q == cmp_i);

  assign link_o.occ   = occ_q;
  assign link_o.found = left_i.found | hit;
  assign link_o.entry = entry_q;

  always_comb begin
    occ_d   = occ_q;
    entry_d = entry_q;
    unique case (cmd_i)
      CMD_APPEND: begin
        // First free slot takes the new word.
        if (!occ_q && left_i.occ) begin
          occ_d   = 1'b1;
          entry_d = value_i;
        end
      end
      CMD_INSERT: begin
        if (left_i.found) begin
          occ_d   = left_i.occ;
          entry_d = left_i.entry;
        end else if (hit) begin
          entry_d = value_i;
        end
      end
      CMD_DELETE: begin
        // Drop the first match and pull everything behind it one step left.
        if (left_i.found || hit) begin
          occ_d   = right_occ_i;
          entry_d = right_entry_i;
        end
      end
      default: begin
        occ_d   = occ_q;
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> hw/rtl/ordered_value_list_engine_top.sv
// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells, one word
// per cell, front at cell 0. Every accepted input word yields exactly one result word.
// Append, insert-before and read register the item on acceptance; the compare and
// shift then settle along the chain and the result is registered. Delete removes
// one matching entry per cycle through the same chain until no match is left, then
// registers its result. One item is worked at a time; the next is accepted once the
// result register is free or being emptied. There is no clearing pass after reset.
module ordered_value_list_engine_top
  import ovle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  state_e          state_q, state_d;
  in_item_t        item_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] removed_q, removed_d;
  logic            out_valid_q;
  out_item_t       out_item_q;

  cell_cmd_e       cmd;
  logic            finish;
  out_item_t       res;
  logic            in_fire;
  logic            full;
  logic            any_hit;
  value_t          cmp_val;
  value_t          rd_val;

  cell_link_t      links [CAPACITY];
  logic [CAPACITY-1:0] occ_vec;

  assign in_fire = in_valid_i && in_ready_o;
  assign full    = (count_q == CntW'(CAPACITY));
  assign any_hit = links[CAPACITY-1].found;
  assign cmp_val = (item_q.op == OP_INSERT) ? item_q.match_key : item_q.value;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left;
    logic       right_occ;
    value_t     right_entry;

    if (i == 0) begin : g_head
      assign left = '{occ: 1'b1, found: 1'b0, entry: '0};
    end else begin : g_body
      assign left = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_occ   = 1'b0;
      assign right_entry = '0;
    end else begin : g_mid
      assign right_occ   = links[i+1].occ;
      assign right_entry = links[i+1].entry;
    end

    ovle_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .value_i      (item_q.value),
      .cmp_i        (cmp_val),
      .left_i       (left),
      .right_occ_i  (right_occ),
      .right_entry_i(right_entry),
      .link_o       (links[i])
    );

    assign occ_vec[i] = links[i].occ;
  end

  always_comb begin
    rd_val = '0;
    for (int i = 0; i < ReadSpan; i++) begin
      if (IdxInW'(i) == item_q.index) begin
        rd_val = links[i].entry;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_EXEC;
      S_EXEC:  if (finish)  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    cmd        = CMD_HOLD;
    finish     = 1'b0;
    count_d    = count_q;
    removed_d  = removed_q;
    res        = '{status: ST_DONE, length: '0, read_value: '0, removed_count: '0};

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_fire) begin
          removed_d = '0;
        end
      end
      S_EXEC: begin
        unique case (item_q.op)
          OP_APPEND: begin
            finish = 1'b1;
            if (full) begin
              res.status = ST_FULL;
            end else begin
              cmd     = CMD_APPEND;
              count_d = count_q + 1'b1;
            end
          end
          OP_INSERT: begin
            finish = 1'b1;
            if (full) begin
              res.status = ST_FULL;
            end else if (!any_hit) begin
              res.status = ST_ABSENT;
            end else begin
              cmd     = CMD_INSERT;
              count_d = count_q + 1'b1;
            end
          end
          OP_DELETE: begin
            if (any_hit) begin
              cmd       = CMD_DELETE;
              count_d   = count_q - 1'b1;
              removed_d = removed_q + 1'b1;
            end else begin
              finish            = 1'b1;
              res.removed_count = LenW'(removed_q);
            end
          end
          OP_READ: begin
            finish = 1'b1;
            if (CmpW'(item_q.index) >= CmpW'(count_q)) begin
              res.status = ST_RANGE;
            end else begin
              res.read_value = rd_val;
            end
          end
          default: finish = 1'b1;
        endcase
        res.length = LenW'(count_d);
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      removed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      removed_q <= removed_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
    if (finish) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(CAPACITY) >= count_q)
    else $error("list length exceeds capacity");

  a_occ_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_vec) == int'(count_q))
    else $error("occupied cells disagree with length");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result word produced outside execution");

  a_occ_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ_vec & (occ_vec + 1'b1)) == '0))
    else $error("occupied cells are not a solid prefix");
`endif

endmodule
